@@ rtl/two_level_page_translate_lru_unit_assert.svh @@
// ----------------------------------------------------------------------------
// two_level_page_translate_lru_unit assertion macros
// shorthand for clocked implication checks with active-low reset disable
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TRANSLATE_LRU_UNIT_ASSERT_SVH
`define TWO_LEVEL_PAGE_TRANSLATE_LRU_UNIT_ASSERT_SVH

// same-cycle implication
`define TPLRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPLRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tplru_pkg.sv @@
// ----------------------------------------------------------------------------
// tplru_pkg
// shared widths, defaults and controller/datapath command and status types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tplru_pkg;

    localparam int DEF_NUM_FRAMES           = 64;
    localparam int DEF_NUM_PROCESSES        = 4;
    localparam int DEF_MAX_FIRST_LEVEL_BITS = 10;
    localparam int DEF_PAGE_OFFSET_BITS     = 12;

    localparam int VADDR_W     = 32;
    localparam int PID_W       = 2;
    localparam int FRAME_OUT_W = 6;
    localparam int PADDR_W     = 18;
    localparam int EVPAGE_W    = 20;
    localparam int FLB_W       = 4;

    localparam logic [FLB_W-1:0] FLB_RESET = 4'd8;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic match;
        logic resolve;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic pid_ok;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/tplru_if.sv @@
// ----------------------------------------------------------------------------
// tplru channel interfaces
// access request channel and translation result channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tplru_req_if
    import tplru_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PID_W-1:0]   process_id;
    logic [VADDR_W-1:0] virtual_address;

    modport source (output valid, output process_id, output virtual_address, input ready);
    modport sink   (input valid, input process_id, input virtual_address, output ready);
endinterface

interface tplru_rsp_if
    import tplru_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   page_hit;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic [PADDR_W-1:0]     physical_address;
    logic                   new_second_table;
    logic                   evicted_valid;
    logic [PID_W-1:0]       evicted_process;
    logic [EVPAGE_W-1:0]    evicted_page;

    modport source (
        output valid, output page_hit, output frame_number, output physical_address,
        output new_second_table, output evicted_valid, output evicted_process,
        output evicted_page, input ready
    );
    modport sink (
        input valid, input page_hit, input frame_number, input physical_address,
        input new_second_table, input evicted_valid, input evicted_process,
        input evicted_page, output ready
    );
endinterface

`default_nettype wire

@@ rtl/two_level_page_translate_lru_unit.sv @@
// ----------------------------------------------------------------------------
// two_level_page_translate_lru_unit
// per-process two-level page translation onto a shared lru frame pool
//
// channel      dir  handshake     payload
// i_req        in   valid/ready   process_id, virtual_address
// o_rsp        out  valid/ready   page_hit, frame_number, physical_address,
//                                 new_second_table, evicted_valid/process/page
// i_cfg_we     in   write enable  i_cfg_wdata -> first_level_bits
//
// each transaction steps through accept, frame tag match, resolve, lru rank update
// the shared frame tag and rank registers serve one transaction at a time
// after reset the touched-table memory is cleared, one entry a cycle:
//   NUM_PROCESSES << MAX_FIRST_LEVEL_BITS entries (4096 by default)
// a transaction with an out-of-range process id is taken and dropped
// a stalled o_rsp holds the next transaction in its update step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_translate_lru_unit
    import tplru_pkg::*;
#(
    parameter int NUM_FRAMES           = DEF_NUM_FRAMES,
    parameter int NUM_PROCESSES        = DEF_NUM_PROCESSES,
    parameter int MAX_FIRST_LEVEL_BITS = DEF_MAX_FIRST_LEVEL_BITS,
    parameter int PAGE_OFFSET_BITS     = DEF_PAGE_OFFSET_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    tplru_req_if.sink             i_req,
    tplru_rsp_if.source           o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [FLB_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tplru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tplru_dp #(
        .NUM_FRAMES           (NUM_FRAMES),
        .NUM_PROCESSES        (NUM_PROCESSES),
        .MAX_FIRST_LEVEL_BITS (MAX_FIRST_LEVEL_BITS),
        .PAGE_OFFSET_BITS     (PAGE_OFFSET_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_process_id       (i_req.process_id),
        .i_virtual_address  (i_req.virtual_address),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_page_hit         (o_rsp.page_hit),
        .o_frame_number     (o_rsp.frame_number),
        .o_physical_address (o_rsp.physical_address),
        .o_new_second_table (o_rsp.new_second_table),
        .o_evicted_valid    (o_rsp.evicted_valid),
        .o_evicted_process  (o_rsp.evicted_process),
        .o_evicted_page     (o_rsp.evicted_page)
    );

endmodule

`default_nettype wire

@@ rtl/tplru_ctrl.sv @@
// ----------------------------------------------------------------------------
// tplru_ctrl
// sequencer: touched-table clear, accept, frame match, resolve, update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tplru_ctrl
    import tplru_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_MATCH   = 5'b00100,
        S_RESOLVE = 5'b01000,
        S_UPDATE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.pid_ok) begin
                        n_state = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_RESOLVE;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tplru_dp.sv @@
// ----------------------------------------------------------------------------
// tplru_dp
// frame tags, lru ranks, touched-table memory and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tplru_dp
    import tplru_pkg::*;
#(
    parameter int NUM_FRAMES           = DEF_NUM_FRAMES,
    parameter int NUM_PROCESSES        = DEF_NUM_PROCESSES,
    parameter int MAX_FIRST_LEVEL_BITS = DEF_MAX_FIRST_LEVEL_BITS,
    parameter int PAGE_OFFSET_BITS     = DEF_PAGE_OFFSET_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_cfg_we,
    input  wire logic [FLB_W-1:0]       i_cfg_wdata,
    input  wire logic [PID_W-1:0]       i_process_id,
    input  wire logic [VADDR_W-1:0]     i_virtual_address,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_page_hit,
    output logic [FRAME_OUT_W-1:0]      o_frame_number,
    output logic [PADDR_W-1:0]          o_physical_address,
    output logic                        o_new_second_table,
    output logic                        o_evicted_valid,
    output logic [PID_W-1:0]            o_evicted_process,
    output logic [EVPAGE_W-1:0]         o_evicted_page
);

    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int VPN_W       = VADDR_W - PAGE_OFFSET_BITS;
    localparam int TOUCH_DEPTH = NUM_PROCESSES << MAX_FIRST_LEVEL_BITS;
    localparam int TIDX_W      = $clog2(TOUCH_DEPTH);

    localparam logic [VADDR_W-1:0] FIRST_MASK = VADDR_W'((64'd1 << MAX_FIRST_LEVEL_BITS) - 1);

    // configuration
    logic [FLB_W-1:0] r_flb;
    logic [FLB_W-1:0] w_flb_eff;

    // request
    logic [PID_W-1:0]            r_pid;
    logic [VPN_W-1:0]            r_vpn;
    logic [PAGE_OFFSET_BITS-1:0] r_offset;

    // touched-table memory
    logic              r_touched [TOUCH_DEPTH];
    logic              r_touched_rd;
    logic [TIDX_W-1:0] r_clr_cnt;
    logic [VADDR_W-1:0] w_first;
    logic [TIDX_W-1:0] w_tidx;
    logic              w_pid_ok;
    logic              w_mem_we;
    logic [TIDX_W-1:0] w_mem_addr;
    logic              w_mem_wd;

    // frame store
    logic               r_in_use [NUM_FRAMES];
    logic [PID_W-1:0]   r_owner  [NUM_FRAMES];
    logic [VPN_W-1:0]   r_page   [NUM_FRAMES];
    logic [FRAME_W-1:0] r_rank   [NUM_FRAMES];

    // match stage
    logic [NUM_FRAMES-1:0] r_match;
    logic [NUM_FRAMES-1:0] r_victim;
    logic                  r_newtab;

    // resolve stage
    logic                  w_hit;
    logic [NUM_FRAMES-1:0] w_sel;
    logic [FRAME_W-1:0]    w_sel_frame;
    logic                  w_sel_in_use;
    logic [PID_W-1:0]      w_sel_owner;
    logic [VPN_W-1:0]      w_sel_page;
    logic [FRAME_W-1:0]    w_sel_rank;

    logic               r_hit;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_sel_rank;
    logic               r_ev_valid;
    logic [PID_W-1:0]   r_ev_owner;
    logic [VPN_W-1:0]   r_ev_page;

    // result register
    logic                   r_out_valid;
    logic                   r_o_hit;
    logic [FRAME_OUT_W-1:0] r_o_frame;
    logic [PADDR_W-1:0]     r_o_paddr;
    logic                   r_o_newtab;
    logic                   r_o_ev_valid;
    logic [PID_W-1:0]       r_o_ev_proc;
    logic [EVPAGE_W-1:0]    r_o_ev_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flb <= FLB_RESET;
        end else if (i_cfg_we) begin
            r_flb <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_flb == '0) begin
            w_flb_eff = FLB_W'(1);
        end else if (r_flb > FLB_W'(MAX_FIRST_LEVEL_BITS)) begin
            w_flb_eff = FLB_W'(MAX_FIRST_LEVEL_BITS);
        end else begin
            w_flb_eff = r_flb;
        end
    end

    assign w_first  = i_virtual_address >> (6'(VADDR_W) - 6'(w_flb_eff));
    assign w_tidx   = TIDX_W'((VADDR_W'(i_process_id) << MAX_FIRST_LEVEL_BITS)
                              | (w_first & FIRST_MASK));
    assign w_pid_ok = VADDR_W'(i_process_id) < VADDR_W'(NUM_PROCESSES);

    assign w_mem_we   = i_cmd.clear_step | (i_cmd.accept & w_pid_ok);
    assign w_mem_addr = i_cmd.clear_step ? r_clr_cnt : w_tidx;
    assign w_mem_wd   = ~i_cmd.clear_step;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_touched[w_mem_addr] <= w_mem_wd;
        end
        if (i_cmd.accept) begin
            r_touched_rd <= r_touched[w_tidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_cnt <= r_clr_cnt + TIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pid    <= i_process_id;
            r_vpn    <= i_virtual_address[VADDR_W-1:PAGE_OFFSET_BITS];
            r_offset <= i_virtual_address[PAGE_OFFSET_BITS-1:0];
        end
    end

    // frame tag compare and oldest-frame search
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_match[i]  <= r_in_use[i] && (r_owner[i] == r_pid) && (r_page[i] == r_vpn);
                r_victim[i] <= (r_rank[i] == '0);
            end
            r_newtab <= ~r_touched_rd;
        end
    end

    assign w_hit = |r_match;
    assign w_sel = w_hit ? r_match : r_victim;

    always_comb begin
        w_sel_frame  = '0;
        w_sel_in_use = 1'b0;
        w_sel_owner  = '0;
        w_sel_page   = '0;
        w_sel_rank   = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (w_sel[i]) begin
                w_sel_frame  = w_sel_frame | FRAME_W'(i);
                w_sel_in_use = w_sel_in_use | r_in_use[i];
                w_sel_owner  = w_sel_owner | r_owner[i];
                w_sel_page   = w_sel_page | r_page[i];
                w_sel_rank   = w_sel_rank | r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_hit      <= w_hit;
            r_frame    <= w_sel_frame;
            r_sel_rank <= w_sel_rank;
            r_ev_valid <= ~w_hit & w_sel_in_use;
            r_ev_owner <= (~w_hit & w_sel_in_use) ? w_sel_owner : '0;
            r_ev_page  <= (~w_hit & w_sel_in_use) ? w_sel_page : '0;
        end
    end

    // frame load and lru rank update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_in_use[i] <= 1'b0;
                r_rank[i]   <= FRAME_W'(i);
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (FRAME_W'(i) == r_frame) begin
                    r_rank[i] <= FRAME_W'(NUM_FRAMES - 1);
                    if (!r_hit) begin
                        r_in_use[i] <= 1'b1;
                    end
                end else if (r_rank[i] > r_sel_rank) begin
                    r_rank[i] <= r_rank[i] - FRAME_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_hit) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (FRAME_W'(i) == r_frame) begin
                    r_owner[i] <= r_pid;
                    r_page[i]  <= r_vpn;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_o_hit      <= r_hit;
            r_o_frame    <= FRAME_OUT_W'(r_frame);
            r_o_paddr    <= PADDR_W'({r_frame, r_offset});
            r_o_newtab   <= r_newtab;
            r_o_ev_valid <= r_ev_valid;
            r_o_ev_proc  <= r_ev_owner;
            r_o_ev_page  <= EVPAGE_W'(r_ev_page);
        end
    end

    assign o_sts.clear_last = (r_clr_cnt == TIDX_W'(TOUCH_DEPTH - 1));
    assign o_sts.pid_ok     = w_pid_ok;
    assign o_sts.out_free   = ~r_out_valid | i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_page_hit         = r_o_hit;
    assign o_frame_number     = r_o_frame;
    assign o_physical_address = r_o_paddr;
    assign o_new_second_table = r_o_newtab;
    assign o_evicted_valid    = r_o_ev_valid;
    assign o_evicted_process  = r_o_ev_proc;
    assign o_evicted_page     = r_o_ev_page;

endmodule

`default_nettype wire

@@ rtl/tplru_chk.sv @@
// ----------------------------------------------------------------------------
// tplru_chk
// port-level checks on the translation unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_level_page_translate_lru_unit_assert.svh"

module tplru_chk
    import tplru_pkg::*;
#(
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic [PID_W-1:0]       i_process_id,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic                   i_page_hit,
    input wire logic [FRAME_OUT_W-1:0] i_frame_number,
    input wire logic [PADDR_W-1:0]     i_physical_address,
    input wire logic                   i_evicted_valid,
    input wire logic [PID_W-1:0]       i_evicted_process,
    input wire logic [EVPAGE_W-1:0]    i_evicted_page
);

    logic w_take;

    assign w_take = i_in_valid && i_in_ready
                    && (VADDR_W'(i_process_id) < VADDR_W'(NUM_PROCESSES));

    `TPLRU_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_frame_number) && $stable(i_physical_address) && $stable(i_evicted_page), "stalled result transaction changed")

    `TPLRU_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, w_take, !i_in_ready, "request taken while a translation is in flight")

    `TPLRU_ASSERT_IMP(a_hit_no_evict, i_clk, i_rst_n, i_out_valid && i_page_hit, !i_evicted_valid && (i_evicted_process == '0) && (i_evicted_page == '0), "hit reports an eviction")

    `TPLRU_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(w_take, 4), "result without a request four cycles earlier")

endmodule

bind two_level_page_translate_lru_unit tplru_chk #(
    .NUM_PROCESSES (NUM_PROCESSES)
) u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_process_id       (i_req.process_id),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_page_hit         (o_rsp.page_hit),
    .i_frame_number     (o_rsp.frame_number),
    .i_physical_address (o_rsp.physical_address),
    .i_evicted_valid    (o_rsp.evicted_valid),
    .i_evicted_process  (o_rsp.evicted_process),
    .i_evicted_page     (o_rsp.evicted_page)
);

`default_nettype wire
